// File: src/assert_macros.svh
// Assertion macros shared by the cluster chain engine modules.
// Every macro samples on clk and expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// File: src/fcc_pkg.sv
// Package for the FAT cluster chain engine: sizes, codes, payload structs,
// datapath operation codes and the sequencer/datapath interface structs.
// No dependencies.
package fcc_pkg;

  localparam int TABLE_DEPTH         = 2048;
  localparam int SECTORS_PER_CLUSTER = 4;
  localparam int DATA_START          = 13;
  localparam int TOTAL_RESET         = 2048;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W  = $clog2(TABLE_DEPTH + 1);

  typedef logic [15:0]       link_t;
  typedef logic [11:0]       free_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  localparam link_t LINK_END  = 16'hFFFF;
  localparam link_t LINK_FREE = 16'h0000;

  localparam int    BOUND_RESET = (TOTAL_RESET < TABLE_DEPTH) ? TOTAL_RESET : TABLE_DEPTH;
  localparam free_t FREE_RESET  = free_t'(BOUND_RESET - 1);

  localparam logic [2:0] ACT_FORMAT = 3'd0;
  localparam logic [2:0] ACT_ALLOC  = 3'd1;
  localparam logic [2:0] ACT_FREE   = 3'd2;
  localparam logic [2:0] ACT_LOOKUP = 3'd3;
  localparam logic [2:0] ACT_EXTEND = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_PASTEND = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] start_cluster;
    logic [10:0] link_count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cluster;
    logic [13:0] first_sector;
    logic [1:0]  status;
    logic        new_first;
    logic [11:0] free_count;
  } result_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_FMT_INIT,   // ptr <= 0, free count from bound
    OP_FMT_WR,     // clear entry ptr (entry 0 gets end mark), ptr++
    OP_READ_CUR,   // read link of cur
    OP_FREE_WR,    // free entry cur, cur <= its old link
    OP_ADV,        // cur <= link, count--
    OP_SET_OK,     // result cluster <= cur
    OP_PAST,       // status past end
    OP_NOSPACE,    // status no free cluster
    OP_TAKE_FIRST, // cur <= grabbed cluster, mark new first
    OP_LINK_NEW,   // link cur -> grabbed cluster, advance, count--
    OP_PTR_CLR,    // ptr <= 0
    OP_SCAN_RD,    // read entry ptr+1, ptr++
    OP_GRAB_HIT,   // mark entry ptr end of chain, take it
    OP_GRAB_MISS,  // no free entry
    OP_RES_GNEW,   // result cluster <= grabbed cluster
    OP_FINISH      // register result, strobe
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } ctl_t;

  typedef struct packed {
    logic cur_bad;
    logic cur_not_end;
    logic cnt_zero;
    logic link_not_end;
    logic gfail;
    logic scan_go;
    logic ptr_out;
    logic fmt_more;
  } flags_t;

endpackage

// File: src/fcc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module fcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fcc_useq.sv
// Microcode sequencer: step counter, return register, control ROM and
// condition select. Uses fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_useq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    action,
  input  fcc_pkg::flags_t flags,
  output fcc_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [4:0] {
    S_IDLE, S_FMT_INIT, S_FMT_LOOP, S_DONE,
    S_ALLOC, S_ALLOC_CHK, S_ALLOC_OK,
    S_FREE_TEST, S_FREE_WR,
    S_LK_TEST, S_LK_READ, S_LK_ADV,
    S_EX, S_EX_G, S_EX_GCHK, S_EX_FIRST, S_EX_VAL, S_EX_LOOP, S_EX_CHK,
    S_EX_NG, S_EX_NCHK, S_EX_LINK, S_EX_ADV,
    S_OK, S_PAST, S_NOSPACE,
    S_GRAB, S_GRAB_RD, S_GRAB_SCAN, S_GRAB_END, S_GRAB_HIT, S_GRAB_MISS
  } step_t;

  typedef enum logic [2:0] {SQ_NEXT, SQ_JUMP, SQ_CALL, SQ_RET, SQ_IDLE} seq_t;

  typedef enum logic [3:0] {
    C_TRUE, C_CUR_BAD, C_CUR_NOT_END, C_CNT_ZERO, C_LINK_NOT_END,
    C_GFAIL, C_SCAN_GO, C_PTR_OUT, C_FMT_MORE
  } cond_t;

  typedef struct packed {
    seq_t          seq;
    cond_t         cond;
    step_t         target;
    fcc_pkg::op_t  op;
    logic          op_if_taken;
  } uword_t;

  function automatic uword_t uw(input seq_t sq, input cond_t cd, input step_t tg,
                                input fcc_pkg::op_t o, input logic gate);
    uword_t w;
    w.seq         = sq;
    w.cond        = cd;
    w.target      = tg;
    w.op          = o;
    w.op_if_taken = gate;
    return w;
  endfunction

  // Control store.
  function automatic uword_t rom(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:      w = uw(SQ_IDLE, C_TRUE, S_IDLE, fcc_pkg::OP_NONE, 1'b0);
      S_FMT_INIT:  w = uw(SQ_NEXT, C_TRUE, S_IDLE, fcc_pkg::OP_FMT_INIT, 1'b0);
      S_FMT_LOOP:  w = uw(SQ_JUMP, C_FMT_MORE, S_FMT_LOOP, fcc_pkg::OP_FMT_WR, 1'b0);
      S_DONE:      w = uw(SQ_IDLE, C_TRUE, S_IDLE, fcc_pkg::OP_FINISH, 1'b0);
      S_ALLOC:     w = uw(SQ_CALL, C_TRUE, S_GRAB, fcc_pkg::OP_NONE, 1'b0);
      S_ALLOC_CHK: w = uw(SQ_JUMP, C_GFAIL, S_NOSPACE, fcc_pkg::OP_NONE, 1'b0);
      S_ALLOC_OK:  w = uw(SQ_JUMP, C_TRUE, S_DONE, fcc_pkg::OP_RES_GNEW, 1'b0);
      S_FREE_TEST: w = uw(SQ_JUMP, C_CUR_BAD, S_DONE, fcc_pkg::OP_READ_CUR, 1'b0);
      S_FREE_WR:   w = uw(SQ_JUMP, C_TRUE, S_FREE_TEST, fcc_pkg::OP_FREE_WR, 1'b0);
      S_LK_TEST:   w = uw(SQ_JUMP, C_CUR_BAD, S_PAST, fcc_pkg::OP_NONE, 1'b0);
      S_LK_READ:   w = uw(SQ_JUMP, C_CNT_ZERO, S_OK, fcc_pkg::OP_READ_CUR, 1'b0);
      S_LK_ADV:    w = uw(SQ_JUMP, C_TRUE, S_LK_TEST, fcc_pkg::OP_ADV, 1'b0);
      S_EX:        w = uw(SQ_JUMP, C_CUR_NOT_END, S_EX_VAL, fcc_pkg::OP_NONE, 1'b0);
      S_EX_G:      w = uw(SQ_CALL, C_TRUE, S_GRAB, fcc_pkg::OP_NONE, 1'b0);
      S_EX_GCHK:   w = uw(SQ_JUMP, C_GFAIL, S_NOSPACE, fcc_pkg::OP_NONE, 1'b0);
      S_EX_FIRST:  w = uw(SQ_JUMP, C_TRUE, S_EX_LOOP, fcc_pkg::OP_TAKE_FIRST, 1'b0);
      S_EX_VAL:    w = uw(SQ_JUMP, C_CUR_BAD, S_PAST, fcc_pkg::OP_NONE, 1'b0);
      S_EX_LOOP:   w = uw(SQ_JUMP, C_CNT_ZERO, S_OK, fcc_pkg::OP_READ_CUR, 1'b0);
      S_EX_CHK:    w = uw(SQ_JUMP, C_LINK_NOT_END, S_EX_ADV, fcc_pkg::OP_NONE, 1'b0);
      S_EX_NG:     w = uw(SQ_CALL, C_TRUE, S_GRAB, fcc_pkg::OP_NONE, 1'b0);
      S_EX_NCHK:   w = uw(SQ_JUMP, C_GFAIL, S_NOSPACE, fcc_pkg::OP_NONE, 1'b0);
      S_EX_LINK:   w = uw(SQ_JUMP, C_TRUE, S_EX_LOOP, fcc_pkg::OP_LINK_NEW, 1'b0);
      S_EX_ADV:    w = uw(SQ_JUMP, C_TRUE, S_EX_VAL, fcc_pkg::OP_ADV, 1'b0);
      S_OK:        w = uw(SQ_JUMP, C_TRUE, S_DONE, fcc_pkg::OP_SET_OK, 1'b0);
      S_PAST:      w = uw(SQ_JUMP, C_TRUE, S_DONE, fcc_pkg::OP_PAST, 1'b0);
      S_NOSPACE:   w = uw(SQ_JUMP, C_TRUE, S_DONE, fcc_pkg::OP_NOSPACE, 1'b0);
      S_GRAB:      w = uw(SQ_NEXT, C_TRUE, S_IDLE, fcc_pkg::OP_PTR_CLR, 1'b0);
      S_GRAB_RD:   w = uw(SQ_NEXT, C_TRUE, S_IDLE, fcc_pkg::OP_SCAN_RD, 1'b0);
      // one entry per cycle: keep reading while the entry seen is in use and within bound
      S_GRAB_SCAN: w = uw(SQ_JUMP, C_SCAN_GO, S_GRAB_SCAN, fcc_pkg::OP_SCAN_RD, 1'b1);
      S_GRAB_END:  w = uw(SQ_JUMP, C_PTR_OUT, S_GRAB_MISS, fcc_pkg::OP_NONE, 1'b0);
      S_GRAB_HIT:  w = uw(SQ_RET, C_TRUE, S_IDLE, fcc_pkg::OP_GRAB_HIT, 1'b0);
      S_GRAB_MISS: w = uw(SQ_RET, C_TRUE, S_IDLE, fcc_pkg::OP_GRAB_MISS, 1'b0);
      default:     w = uw(SQ_IDLE, C_TRUE, S_IDLE, fcc_pkg::OP_NONE, 1'b0);
    endcase
    return w;
  endfunction

  function automatic step_t entry(input logic [2:0] act);
    step_t s;
    unique case (act)
      fcc_pkg::ACT_FORMAT: s = S_FMT_INIT;
      fcc_pkg::ACT_ALLOC:  s = S_ALLOC;
      fcc_pkg::ACT_FREE:   s = S_FREE_TEST;
      fcc_pkg::ACT_LOOKUP: s = S_LK_TEST;
      fcc_pkg::ACT_EXTEND: s = S_EX;
      default:             s = S_DONE;
    endcase
    return s;
  endfunction

  step_t  pc;
  step_t  ret;
  uword_t word;
  logic   taken;
  step_t  pc_inc;

  assign word   = rom(pc);
  assign pc_inc = step_t'(pc + 5'd1);

  always_comb begin
    unique case (word.cond)
      C_TRUE:         taken = 1'b1;
      C_CUR_BAD:      taken = flags.cur_bad;
      C_CUR_NOT_END:  taken = flags.cur_not_end;
      C_CNT_ZERO:     taken = flags.cnt_zero;
      C_LINK_NOT_END: taken = flags.link_not_end;
      C_GFAIL:        taken = flags.gfail;
      C_SCAN_GO:      taken = flags.scan_go;
      C_PTR_OUT:      taken = flags.ptr_out;
      C_FMT_MORE:     taken = flags.fmt_more;
      default:        taken = 1'b0;
    endcase
  end

  assign busy       = (pc != S_IDLE);
  assign ctl.accept = (pc == S_IDLE) && start;
  assign ctl.op     = (!word.op_if_taken || taken) ? word.op : fcc_pkg::OP_NONE;

  // Reset starts at the clearing loop; the datapath suppresses its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= S_FMT_LOOP;
      ret <= S_IDLE;
    end else if (pc == S_IDLE) begin
      if (start) begin
        pc <= entry(action);
      end
    end else begin
      unique case (word.seq)
        SQ_NEXT: pc <= pc_inc;
        SQ_JUMP: pc <= taken ? word.target : pc_inc;
        SQ_CALL: begin
          pc  <= word.target;
          ret <= pc_inc;
        end
        SQ_RET:  pc <= ret;
        SQ_IDLE: pc <= S_IDLE;
        default: pc <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_accept_leaves_idle, (pc == S_IDLE && start) |=> (pc != S_IDLE), "accepted transaction left sequencer idle")
  `ASSERT_CLK(a_grab_return, (pc == S_GRAB_HIT || pc == S_GRAB_MISS) |-> (ret == S_ALLOC_CHK || ret == S_EX_GCHK || ret == S_EX_NCHK), "allocation subroutine has a bad return step")

endmodule

// File: src/fcc_dpath.sv
// Datapath: link table RAM, walk/scan registers, free counter and result.
// Uses fcc_pkg, fcc_ram and assert_macros.svh.
`include "assert_macros.svh"

module fcc_dpath (
  input  logic              clk,
  input  logic              rst,
  input  fcc_pkg::ctl_t     ctl,
  input  fcc_pkg::cmd_t     cmd,
  input  fcc_pkg::ptr_t     bound,
  output fcc_pkg::flags_t   flags,
  output fcc_pkg::result_t  result,
  output logic              done
);

  fcc_pkg::link_t cur;
  logic [10:0]    cnt;
  fcc_pkg::ptr_t  ptr;
  fcc_pkg::free_t free_cnt;
  logic [1:0]     status;
  logic           fresh;
  fcc_pkg::link_t res_cl;
  fcc_pkg::link_t gnew;
  logic           gfail;
  logic           silent;

  fcc_pkg::ptr_t  ptr_inc;
  logic           we;
  fcc_pkg::addr_t waddr;
  fcc_pkg::link_t wdata;
  logic           re;
  fcc_pkg::addr_t raddr;
  fcc_pkg::link_t rdata;
  logic [13:0]    sector;

  assign ptr_inc = fcc_pkg::ptr_t'(ptr + 1'b1);

  always_comb begin
    we    = 1'b0;
    waddr = ptr[fcc_pkg::ADDR_W-1:0];
    wdata = fcc_pkg::LINK_FREE;
    re    = 1'b0;
    raddr = cur[fcc_pkg::ADDR_W-1:0];
    unique case (ctl.op)
      fcc_pkg::OP_FMT_WR: begin
        we    = 1'b1;
        wdata = (ptr == '0) ? fcc_pkg::LINK_END : fcc_pkg::LINK_FREE;
      end
      fcc_pkg::OP_READ_CUR: re = 1'b1;
      fcc_pkg::OP_FREE_WR: begin
        we    = 1'b1;
        waddr = cur[fcc_pkg::ADDR_W-1:0];
      end
      fcc_pkg::OP_LINK_NEW: begin
        we    = 1'b1;
        waddr = cur[fcc_pkg::ADDR_W-1:0];
        wdata = gnew;
      end
      fcc_pkg::OP_SCAN_RD: begin
        re    = 1'b1;
        raddr = ptr_inc[fcc_pkg::ADDR_W-1:0];
      end
      fcc_pkg::OP_GRAB_HIT: begin
        we    = 1'b1;
        wdata = fcc_pkg::LINK_END;
      end
      default: ;
    endcase
  end

  fcc_ram #(
    .WIDTH(16),
    .DEPTH(fcc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Conditions the sequencer branches on; rdata is the entry read last step.
  assign flags.cur_bad      = (cur == fcc_pkg::LINK_FREE) || (32'(cur) >= fcc_pkg::TABLE_DEPTH);
  assign flags.cur_not_end  = (cur != fcc_pkg::LINK_END);
  assign flags.cnt_zero     = (cnt == '0);
  assign flags.link_not_end = (rdata != fcc_pkg::LINK_END);
  assign flags.gfail        = gfail;
  assign flags.scan_go      = (ptr < bound) && (rdata != fcc_pkg::LINK_FREE);
  assign flags.ptr_out      = (ptr >= bound);
  assign flags.fmt_more     = (32'(ptr) != fcc_pkg::TABLE_DEPTH - 1);

  assign sector = (res_cl == fcc_pkg::LINK_END) ? 14'd0 :
      14'(32'(fcc_pkg::DATA_START) + 32'(res_cl) * 32'(fcc_pkg::SECTORS_PER_CLUSTER));

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      free_cnt <= fcc_pkg::FREE_RESET;
      silent   <= 1'b1;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.accept) begin
        cur    <= cmd.start_cluster;
        cnt    <= cmd.link_count;
        status <= fcc_pkg::ST_OK;
        fresh  <= 1'b0;
        res_cl <= fcc_pkg::LINK_END;
        silent <= 1'b0;
      end
      unique case (ctl.op)
        fcc_pkg::OP_FMT_INIT: begin
          ptr      <= '0;
          free_cnt <= (bound == '0) ? '0 : fcc_pkg::free_t'(32'(bound) - 1);
        end
        fcc_pkg::OP_FMT_WR: ptr <= ptr_inc;
        fcc_pkg::OP_FREE_WR: begin
          cur <= rdata;
          if (free_cnt != 12'hFFF) begin
            free_cnt <= free_cnt + 12'd1;
          end
        end
        fcc_pkg::OP_ADV: begin
          cur <= rdata;
          cnt <= cnt - 11'd1;
        end
        fcc_pkg::OP_SET_OK:  res_cl <= cur;
        fcc_pkg::OP_PAST:    status <= fcc_pkg::ST_PASTEND;
        fcc_pkg::OP_NOSPACE: status <= fcc_pkg::ST_NOSPACE;
        fcc_pkg::OP_TAKE_FIRST: begin
          cur   <= gnew;
          fresh <= 1'b1;
        end
        fcc_pkg::OP_LINK_NEW: begin
          cur <= gnew;
          cnt <= cnt - 11'd1;
        end
        fcc_pkg::OP_PTR_CLR: ptr <= '0;
        fcc_pkg::OP_SCAN_RD: ptr <= ptr_inc;
        fcc_pkg::OP_GRAB_HIT: begin
          gnew  <= fcc_pkg::link_t'(ptr);
          gfail <= 1'b0;
          if (free_cnt != '0) begin
            free_cnt <= free_cnt - 12'd1;
          end
        end
        fcc_pkg::OP_GRAB_MISS: begin
          gnew  <= fcc_pkg::LINK_END;
          gfail <= 1'b1;
        end
        fcc_pkg::OP_RES_GNEW: res_cl <= gnew;
        fcc_pkg::OP_FINISH: begin
          result.cluster      <= res_cl;
          result.first_sector <= sector;
          result.status       <= status;
          result.new_first    <= fresh;
          result.free_count   <= free_cnt;
          done                <= !silent;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_CLK(a_done_after_finish, done |-> $past(ctl.op == fcc_pkg::OP_FINISH), "result strobe without a finish step")
  `ASSERT_CLK(a_grab_in_bound, (ctl.op == fcc_pkg::OP_GRAB_HIT) |-> (ptr != '0 && ptr < bound), "allocated entry outside the scan range")
  `ASSERT_NEVER(a_no_reset_result, done && silent, "result strobed for the clearing pass after reset")

endmodule

// File: src/fat_cluster_chain_engine.sv
// FAT cluster chain engine, top level.
// Command channel: cmd is taken at a clock edge with start high and busy low;
// busy stays high until the transaction's single result has been strobed.
// Result channel: result is valid for the one cycle that done is high; the
// receiver cannot stall it, and a new command may be taken in that cycle.
// Configuration: cfg_we writes total_clusters from cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it.
// Operation: a microcoded sequencer walks the 2048-entry link table RAM
// (one write port, one read port):
//   format      one entry cleared per cycle
//   allocate    scan of up to bound entries at one per cycle
//   free chain  each link read, then freed
//   lookup      each link followed in turn
//   extend      each link followed, plus a scan for each allocation
// Reset (synchronous, rst high) sets total_clusters to 2048 and runs a
// clearing pass over all TABLE_DEPTH entries with busy high; that pass
// produces no result.
module fat_cluster_chain_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fcc_pkg::cmd_t     cmd,
  output logic              done,
  output fcc_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [11:0]       cfg_wdata
);

  logic [11:0]     total_clusters;
  fcc_pkg::ptr_t   bound;
  fcc_pkg::ctl_t   ctl;
  fcc_pkg::flags_t flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_clusters <= 12'(fcc_pkg::TOTAL_RESET);
    end else if (cfg_we) begin
      total_clusters <= cfg_wdata;
    end
  end

  // scan bound = min(total_clusters, TABLE_DEPTH)
  assign bound = (32'(total_clusters) < fcc_pkg::TABLE_DEPTH) ?
      fcc_pkg::ptr_t'(total_clusters) : fcc_pkg::ptr_t'(fcc_pkg::TABLE_DEPTH);

  fcc_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(cmd.action),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  fcc_dpath u_dpath (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .cmd   (cmd),
    .bound (bound),
    .flags (flags),
    .result(result),
    .done  (done)
  );

endmodule

// File: bench/tb_top.sv
// Testbench for fat_cluster_chain_engine: directed and random commands, with each
// result checked against a behavioral copy of the link table and free count.
// Depends on fcc_pkg (src/fcc_pkg.sv) and the engine RTL.
module tb_top;
  import fcc_pkg::*;

  localparam logic [2:0] ACT_NOP_A = 3'd5;
  localparam logic [2:0] ACT_NOP_B = 3'd6;
  localparam logic [2:0] ACT_NOP_C = 3'd7;
  localparam int QUIET_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_bus = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  // behavioral copy of the engine state
  link_t       fat_links [TABLE_DEPTH];
  int unsigned free_left;
  logic [11:0] cluster_limit = 12'd2048;

  cmd_t        cmd_backlog[$];
  result_t     chain_results[$];
  int          bad_results = 0;
  int          quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  fat_cluster_chain_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd_bus),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned scan_limit();
    return (cluster_limit < TABLE_DEPTH) ? cluster_limit : TABLE_DEPTH;
  endfunction

  function automatic bit chain_link_ok(input link_t c);
    return c != LINK_FREE && c < TABLE_DEPTH;
  endfunction

  function automatic void wipe_links();
    int unsigned lim;
    lim = scan_limit();
    for (int i = 0; i < TABLE_DEPTH; i++) fat_links[i] = LINK_FREE;
    fat_links[0] = LINK_END;
    free_left = (lim > 0) ? lim - 1 : 0;
  endfunction

  // first free entry from 1 up, marked end of chain; LINK_END when none
  function automatic link_t claim_first_free();
    int unsigned lim;
    lim = scan_limit();
    for (int unsigned i = 1; i < lim; i++) begin
      if (fat_links[i] == LINK_FREE) begin
        fat_links[i] = LINK_END;
        if (free_left > 0) free_left--;
        return link_t'(i);
      end
    end
    return LINK_END;
  endfunction

  function automatic result_t apply_fat_cmd(input cmd_t c);
    result_t     r;
    link_t       cur, nxt, hit;
    logic [1:0]  st;
    logic        fresh;
    bit          ok;
    int unsigned sect;
    cur   = c.start_cluster;
    hit   = LINK_END;
    st    = ST_OK;
    fresh = 1'b0;
    case (c.action)
      ACT_FORMAT: wipe_links();
      ACT_ALLOC: begin
        hit = claim_first_free();
        if (hit == LINK_END) st = ST_NOSPACE;
      end
      ACT_FREE: begin
        while (cur != LINK_END && chain_link_ok(cur)) begin
          nxt = fat_links[cur];
          fat_links[cur] = LINK_FREE;
          if (free_left < 4095) free_left++;
          cur = nxt;
        end
      end
      ACT_LOOKUP: begin
        ok = chain_link_ok(cur);
        for (int unsigned n = 0; ok && n < c.link_count; n++) begin
          cur = fat_links[cur];
          ok = chain_link_ok(cur);
        end
        if (ok) hit = cur;
        else st = ST_PASTEND;
      end
      ACT_EXTEND: begin
        ok = 1'b1;
        if (cur == LINK_END) begin
          cur = claim_first_free();
          if (cur == LINK_END) begin
            st = ST_NOSPACE;
            ok = 1'b0;
          end else begin
            fresh = 1'b1;
          end
        end else if (!chain_link_ok(cur)) begin
          st = ST_PASTEND;
          ok = 1'b0;
        end
        for (int unsigned n = 0; ok && n < c.link_count; n++) begin
          if (fat_links[cur] == LINK_END) begin
            nxt = claim_first_free();
            if (nxt == LINK_END) begin
              st = ST_NOSPACE;
              ok = 1'b0;
            end else begin
              fat_links[cur] = nxt;
            end
          end
          if (ok) begin
            cur = fat_links[cur];
            if (!chain_link_ok(cur)) begin
              st = ST_PASTEND;
              ok = 1'b0;
            end
          end
        end
        if (ok) hit = cur;
      end
      default: ;
    endcase
    sect = DATA_START + hit * SECTORS_PER_CLUSTER;
    r.cluster      = hit;
    r.first_sector = (hit == LINK_END) ? '0 : sect[13:0];
    r.status       = st;
    r.new_first    = fresh;
    r.free_count   = free_left[11:0];
    return r;
  endfunction

  // driver: a command transaction completes on start && !busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) chain_results.push_back(apply_fat_cmd(cmd_bus));
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 29)) begin
          cmd_bus <= cmd_backlog.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, one per done strobe
  always @(posedge clk) begin
    result_t want;
    bit      stray;
    if (!rst && done) begin
      stray = (chain_results.size() == 0);
      want  = stray ? result_t'('0) : chain_results.pop_front();
      if (stray || result.cluster !== want.cluster
          || result.first_sector !== want.first_sector
          || result.status !== want.status || result.new_first !== want.new_first
          || result.free_count !== want.free_count) begin
        bad_results++;
        if (bad_results <= 10)
          $display("bad result%s: want cl %h sec %0d st %0d nf %0d free %0d, got cl %h sec %0d st %0d nf %0d free %0d",
                   stray ? " (none pending)" : "", want.cluster, want.first_sector,
                   want.status, want.new_first, want.free_count, result.cluster,
                   result.first_sector, result.status, result.new_first,
                   result.free_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL fat_cluster_chain_engine");
    $finish;
  end

  task automatic queue_cmd(input logic [2:0] act, input logic [15:0] first,
                           input logic [10:0] links);
    cmd_backlog.push_back(cmd_t'{action: act, start_cluster: first, link_count: links});
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || start || chain_results.size() != 0 || busy)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= v;
    cluster_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic [11:0] limit, input int n, input bit fmt);
    int unsigned b, hi, r;
    logic [31:0] raw;
    cmd_t        c;
    write_limit(limit);
    b  = scan_limit();
    hi = (b + 2 < 2047) ? b + 2 : 2047;
    if (fmt) queue_cmd(ACT_FORMAT, $urandom, $urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 60) c.start_cluster = $urandom_range(1, hi);
      else if (r < 78) c.start_cluster = LINK_END;
      else if (r < 85) c.start_cluster = '0;
      else c.start_cluster = $urandom_range(65535);
      if (b <= 64 && $urandom_range(9) == 0) c.link_count = $urandom_range(2047);
      else if ($urandom_range(9) == 0) c.link_count = $urandom_range(7, 15);
      else c.link_count = $urandom_range(6);
      r = $urandom_range(99);
      if (r < 3) c.action = ACT_FORMAT;
      else if (r < 27) c.action = ACT_ALLOC;
      else if (r < 40) c.action = ACT_FREE;
      else if (r < 64) c.action = ACT_LOOKUP;
      else if (r < 94) c.action = ACT_EXTEND;
      else if (r < 97) c.action = $urandom_range(ACT_NOP_A, ACT_NOP_C);
      else begin
        raw = $urandom;
        c   = raw[29:0];
      end
      // extends against a wide bound get short link counts, as each allocation scans the table
      if (c.action == ACT_EXTEND && b > 64) c.link_count = c.link_count[3:0];
      queue_cmd(c.action, c.start_cluster, c.link_count);
    end
    wait_idle();
  endtask

  initial begin
    cluster_limit = TOTAL_RESET;
    wipe_links();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default bound: chain building, walks off the end, bad start clusters
    queue_cmd(ACT_LOOKUP, 16'd0, 11'd0);
    queue_cmd(ACT_EXTEND, LINK_END, 11'd0);
    queue_cmd(ACT_EXTEND, 16'd1, 11'd3);
    queue_cmd(ACT_LOOKUP, 16'd1, 11'd3);
    queue_cmd(ACT_LOOKUP, 16'd1, 11'd2047);
    queue_cmd(ACT_EXTEND, 16'd2048, 11'd1);
    queue_cmd(ACT_ALLOC, 16'd0, 11'd0);
    queue_cmd(ACT_FREE, 16'd1, 11'd0);
    queue_cmd(ACT_LOOKUP, 16'd1, 11'd1);
    queue_cmd(ACT_NOP_C, LINK_END, 11'd2047);
    queue_cmd(ACT_NOP_A, 16'd0, 11'd0);
    queue_cmd(ACT_NOP_B, $urandom, $urandom);

    // three clusters: running out of space mid-extend keeps the new links
    write_limit(12'd3);
    queue_cmd(ACT_FORMAT, 16'd0, 11'd0);
    queue_cmd(ACT_ALLOC, 16'd0, 11'd0);
    queue_cmd(ACT_EXTEND, LINK_END, 11'd4);
    queue_cmd(ACT_ALLOC, 16'd0, 11'd0);
    queue_cmd(ACT_LOOKUP, 16'd2, 11'd0);
    queue_cmd(ACT_FREE, 16'd1, 11'd0);
    queue_cmd(ACT_EXTEND, 16'd2, 11'd2);

    write_limit(12'd0);
    queue_cmd(ACT_FORMAT, 16'd0, 11'd0);
    queue_cmd(ACT_ALLOC, 16'd0, 11'd0);

    // free count formatted small, then bound widened: count bottoms out at zero
    write_limit(12'd16);
    queue_cmd(ACT_FORMAT, 16'd0, 11'd0);
    write_limit(12'd4095);
    queue_cmd(ACT_EXTEND, LINK_END, 11'd20);
    queue_cmd(ACT_FREE, 16'd1, 11'd0);
    queue_cmd(ACT_LOOKUP, LINK_END, 11'd5);

    random_phase(12'd40, 35, 1'b1);
    gaps_on = 1'b0;
    random_phase(12'd2048, 30, 1'b1);
    gaps_on = 1'b1;
    random_phase(12'd16, 35, 1'b1);
    random_phase(12'd2, 15, 1'b1);
    random_phase(12'd64, 35, 1'b1);
    random_phase(12'd4095, 25, 1'b0);
    random_phase(12'd9, 30, 1'b1);
    random_phase(12'd1, 10, 1'b0);
    random_phase(12'($urandom_range(2, 300)), 35, 1'b1);

    wait_idle();
    repeat (40) @(posedge clk);
    if (bad_results == 0 && chain_results.size() == 0) begin
      $display("PASS fat_cluster_chain_engine");
    end else begin
      $display("FAIL fat_cluster_chain_engine");
    end
    $finish;
  end

endmodule
